// ===== hdl/tbc_pkg.sv =====
// Package for the trapezoid band clip unit: lane numbering and lane index type.
`timescale 1ns / 1ps
package tbc_pkg;

    // Edge interpolation lanes, lane = {trapezoid, side, band limit}
    localparam int LANES   = 8;
    localparam int LANE_LT = 0;  // left edge at band top
    localparam int LANE_LB = 1;  // left edge at band bottom
    localparam int LANE_RT = 2;  // right edge at band top
    localparam int LANE_RB = 3;  // right edge at band bottom
    localparam int LANE_B  = 4;  // offset of trapezoid B lanes

    typedef logic [2:0] lane_t;

endpackage

// ===== hdl/trapezoid_band_clip_unit.sv =====
// Trapezoid band clip unit: pipelined clip or envelope of two trapezoids over their y overlap.
`timescale 1ns / 1ps
// One pair of trapezoids enters per cycle unless the output stalls. One stage
// forms the band and the edge deltas, one stage multiplies, COORD_WIDTH+1
// stages run a restoring divider that retires one quotient bit each for all
// edge interpolation lanes, and the last stage adds, selects and registers
// the output. A stall on the output freezes the whole pipeline. mode_reg is
// written through the cfg channel, which is always ready; write it only while
// the pipeline is empty.
module trapezoid_band_clip_unit
    import tbc_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] a_left_top,
    input  logic signed [COORD_WIDTH-1:0] a_right_top,
    input  logic signed [COORD_WIDTH-1:0] a_left_bottom,
    input  logic signed [COORD_WIDTH-1:0] a_right_bottom,
    input  logic signed [COORD_WIDTH-1:0] a_y_top,
    input  logic signed [COORD_WIDTH-1:0] a_y_bottom,
    input  logic signed [COORD_WIDTH-1:0] b_left_top,
    input  logic signed [COORD_WIDTH-1:0] b_right_top,
    input  logic signed [COORD_WIDTH-1:0] b_left_bottom,
    input  logic signed [COORD_WIDTH-1:0] b_right_bottom,
    input  logic signed [COORD_WIDTH-1:0] b_y_top,
    input  logic signed [COORD_WIDTH-1:0] b_y_bottom,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          overlap,
    output logic signed [COORD_WIDTH-1:0] out_y_top,
    output logic signed [COORD_WIDTH-1:0] out_y_bottom,
    output logic signed [COORD_WIDTH-1:0] out_left_top,
    output logic signed [COORD_WIDTH-1:0] out_right_top,
    output logic signed [COORD_WIDTH-1:0] out_left_bottom,
    output logic signed [COORD_WIDTH-1:0] out_right_bottom
);

    localparam int W  = COORD_WIDTH;
    localparam int QB = COORD_WIDTH + 1;
    localparam int PW = 2 * QB;

    logic mode_reg;
    logic en;

    // stage 1 combinational
    logic signed [W-1:0]  yt, yb;
    logic                 ok;
    logic signed [QB-1:0] dxs [LANES];
    logic signed [QB-1:0] tss [LANES];
    logic signed [QB-1:0] dss [LANES];
    logic signed [W-1:0]  x1c [LANES];

    // stage 1 registers
    logic                 v1_reg;
    logic [QB-1:0]        dxm1_reg [LANES];
    logic [QB-1:0]        tm1_reg  [LANES];
    logic [QB-1:0]        den1_reg [LANES];
    logic                 neg1_reg [LANES];
    logic signed [W-1:0]  x1_1_reg [LANES];
    logic signed [W-1:0]  yt1_reg, yb1_reg;
    logic                 ok1_reg;

    // multiply and divider stages, index = quotient bits done
    logic                 v_reg    [QB+1];
    logic [QB-1:0]        rem_reg  [QB+1][LANES];
    logic [QB-1:0]        quo_reg  [QB+1][LANES];
    logic [QB-1:0]        den_reg  [QB+1][LANES];
    logic                 neg_reg  [QB+1][LANES];
    logic signed [W-1:0]  x1_reg   [QB+1][LANES];
    logic signed [W-1:0]  yt_reg   [QB+1];
    logic signed [W-1:0]  yb_reg   [QB+1];
    logic                 ok_reg   [QB+1];

    // output stage
    logic signed [W-1:0]  xr [LANES];
    logic signed [W-1:0]  lt_next, rt_next, lb_next, rb_next;
    logic                 out_valid_reg;
    logic                 overlap_reg;
    logic signed [W-1:0]  out_y_top_reg, out_y_bottom_reg;
    logic signed [W-1:0]  out_left_top_reg, out_right_top_reg;
    logic signed [W-1:0]  out_left_bottom_reg, out_right_bottom_reg;

    assign en        = !out_valid_reg || !out_stall;
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            mode_reg <= cfg_data;
        end
    end

    // band limits, x test and per-edge deltas
    always_comb
    begin
        lane_t               li;
        logic signed [W-1:0] tx, bx, ty, by, ev;
        li = '0;
        tx = '0;
        bx = '0;
        ty = '0;
        by = '0;
        ev = '0;
        yt = (a_y_top < b_y_top) ? a_y_top : b_y_top;
        yb = (a_y_bottom > b_y_bottom) ? a_y_bottom : b_y_bottom;
        ok = ((a_right_bottom >= b_left_bottom) || (a_right_top >= b_left_top)) && (yt > yb);
        for (int l = 0; l < LANES; l++)
        begin
            li = lane_t'(l);
            if (!li[2])
            begin
                tx = li[1] ? a_right_top : a_left_top;
                bx = li[1] ? a_right_bottom : a_left_bottom;
                ty = a_y_top;
                by = a_y_bottom;
            end
            else
            begin
                tx = li[1] ? b_right_top : b_left_top;
                bx = li[1] ? b_right_bottom : b_left_bottom;
                ty = b_y_top;
                by = b_y_bottom;
            end
            ev     = li[0] ? yb : yt;
            dxs[l] = {bx[W-1], bx} - {tx[W-1], tx};
            tss[l] = {ev[W-1], ev} - {ty[W-1], ty};
            dss[l] = {by[W-1], by} - {ty[W-1], ty};
            x1c[l] = tx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yt1_reg <= yt;
            yb1_reg <= yb;
            ok1_reg <= ok;
            for (int l = 0; l < LANES; l++)
            begin
                dxm1_reg[l] <= dxs[l][QB-1] ? (~dxs[l] + 1'b1) : dxs[l];
                tm1_reg[l]  <= tss[l][QB-1] ? (~tss[l] + 1'b1) : tss[l];
                den1_reg[l] <= dss[l][QB-1] ? (~dss[l] + 1'b1) : dss[l];
                neg1_reg[l] <= dxs[l][QB-1] ^ tss[l][QB-1] ^ dss[l][QB-1];
                x1_1_reg[l] <= x1c[l];
            end
        end
    end

    // multiply: high half seeds the remainder, low half the dividend/quotient shifter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [PW-1:0] prod;
        if (en)
        begin
            yt_reg[0] <= yt1_reg;
            yb_reg[0] <= yb1_reg;
            ok_reg[0] <= ok1_reg;
            for (int l = 0; l < LANES; l++)
            begin
                prod           = PW'(dxm1_reg[l]) * PW'(tm1_reg[l]);
                rem_reg[0][l] <= prod[PW-1:QB];
                quo_reg[0][l] <= prod[QB-1:0];
                den_reg[0][l] <= den1_reg[l];
                neg_reg[0][l] <= neg1_reg[l];
                x1_reg[0][l]  <= x1_1_reg[l];
            end
        end
    end

    // restoring divider, one quotient bit per stage; quotient never exceeds |dx| when the pair overlaps
    for (genvar k = 1; k <= QB; k++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            logic [QB:0] tr;
            logic [QB:0] diff;
            if (en)
            begin
                yt_reg[k] <= yt_reg[k-1];
                yb_reg[k] <= yb_reg[k-1];
                ok_reg[k] <= ok_reg[k-1];
                for (int l = 0; l < LANES; l++)
                begin
                    tr   = {rem_reg[k-1][l], quo_reg[k-1][l][QB-1]};
                    diff = tr - {1'b0, den_reg[k-1][l]};
                    rem_reg[k][l] <= diff[QB] ? tr[QB-1:0] : diff[QB-1:0];
                    quo_reg[k][l] <= {quo_reg[k-1][l][QB-2:0], !diff[QB]};
                    den_reg[k][l] <= den_reg[k-1][l];
                    neg_reg[k][l] <= neg_reg[k-1][l];
                    x1_reg[k][l]  <= x1_reg[k-1][l];
                end
            end
        end
    end

    // apply quotient, then keep inner edges or outer envelope
    always_comb
    begin
        logic [QB-1:0] sx;
        sx = '0;
        for (int l = 0; l < LANES; l++)
        begin
            sx = {x1_reg[QB][l][W-1], x1_reg[QB][l]};
            sx = neg_reg[QB][l] ? (sx - quo_reg[QB][l]) : (sx + quo_reg[QB][l]);
            xr[l] = sx[W-1:0];
        end
        if (mode_reg)
        begin
            lt_next = (xr[LANE_LT] < xr[LANE_B+LANE_LT]) ? xr[LANE_LT] : xr[LANE_B+LANE_LT];
            lb_next = (xr[LANE_LB] < xr[LANE_B+LANE_LB]) ? xr[LANE_LB] : xr[LANE_B+LANE_LB];
            rt_next = (xr[LANE_RT] > xr[LANE_B+LANE_RT]) ? xr[LANE_RT] : xr[LANE_B+LANE_RT];
            rb_next = (xr[LANE_RB] > xr[LANE_B+LANE_RB]) ? xr[LANE_RB] : xr[LANE_B+LANE_RB];
        end
        else
        begin
            lt_next = (xr[LANE_LT] > xr[LANE_B+LANE_LT]) ? xr[LANE_LT] : xr[LANE_B+LANE_LT];
            lb_next = (xr[LANE_LB] > xr[LANE_B+LANE_LB]) ? xr[LANE_LB] : xr[LANE_B+LANE_LB];
            rt_next = (xr[LANE_RT] < xr[LANE_B+LANE_RT]) ? xr[LANE_RT] : xr[LANE_B+LANE_RT];
            rb_next = (xr[LANE_RB] < xr[LANE_B+LANE_RB]) ? xr[LANE_RB] : xr[LANE_B+LANE_RB];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            overlap_reg          <= ok_reg[QB];
            out_y_top_reg        <= ok_reg[QB] ? yt_reg[QB] : '0;
            out_y_bottom_reg     <= ok_reg[QB] ? yb_reg[QB] : '0;
            out_left_top_reg     <= ok_reg[QB] ? lt_next : '0;
            out_right_top_reg    <= ok_reg[QB] ? rt_next : '0;
            out_left_bottom_reg  <= ok_reg[QB] ? lb_next : '0;
            out_right_bottom_reg <= ok_reg[QB] ? rb_next : '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign overlap          = overlap_reg;
    assign out_y_top        = out_y_top_reg;
    assign out_y_bottom     = out_y_bottom_reg;
    assign out_left_top     = out_left_top_reg;
    assign out_right_top    = out_right_top_reg;
    assign out_left_bottom  = out_left_bottom_reg;
    assign out_right_bottom = out_right_bottom_reg;

`ifndef SYNTHESIS
    a_no_overlap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !overlap) |-> (out_y_top == 0 && out_y_bottom == 0 &&
        out_left_top == 0 && out_right_top == 0 &&
        out_left_bottom == 0 && out_right_bottom == 0))
        else $error("non-overlap word carries nonzero coordinates");

    a_band_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overlap) |-> (out_y_top > out_y_bottom))
        else $error("overlap word with empty band");

    a_held_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_left_top)))
        else $error("stalled result word lost");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1_reg)
        else $error("accepted word not captured in first stage");
`endif

endmodule

// ===== tb/tb.sv =====
// Testbench for trapezoid_band_clip_unit: directed and random pairs against a band predictor.
`timescale 1ns / 1ps
module tb;

    localparam int CW = 32;
    localparam longint CMAX = 64'sd2147483647;
    localparam longint CMIN = -64'sd2147483648;
    localparam int LATENCY = CW + 4;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        coord_t alt, art, alb, arb, ayt, ayb;
        coord_t blt, brt, blb, brb, byt, byb;
    } pair_t;

    typedef struct {
        logic   hit;
        coord_t yt, yb, lt, rt, lb, rb;
    } band_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic cfg_data = 0;
    logic in_valid = 0;
    logic in_stall;
    coord_t a_left_top = 0, a_right_top = 0, a_left_bottom = 0, a_right_bottom = 0;
    coord_t a_y_top = 0, a_y_bottom = 0;
    coord_t b_left_top = 0, b_right_top = 0, b_left_bottom = 0, b_right_bottom = 0;
    coord_t b_y_top = 0, b_y_bottom = 0;
    logic out_valid;
    logic out_stall = 0;
    logic overlap;
    coord_t out_y_top, out_y_bottom, out_left_top, out_right_top;
    coord_t out_left_bottom, out_right_bottom;

    band_t expected_bands[$];
    logic union_mode = 0;
    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;

    trapezoid_band_clip_unit #(.COORD_WIDTH(CW)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .a_left_top(a_left_top), .a_right_top(a_right_top),
        .a_left_bottom(a_left_bottom), .a_right_bottom(a_right_bottom),
        .a_y_top(a_y_top), .a_y_bottom(a_y_bottom),
        .b_left_top(b_left_top), .b_right_top(b_right_top),
        .b_left_bottom(b_left_bottom), .b_right_bottom(b_right_bottom),
        .b_y_top(b_y_top), .b_y_bottom(b_y_bottom),
        .out_valid(out_valid), .out_stall(out_stall),
        .overlap(overlap),
        .out_y_top(out_y_top), .out_y_bottom(out_y_bottom),
        .out_left_top(out_left_top), .out_right_top(out_right_top),
        .out_left_bottom(out_left_bottom), .out_right_bottom(out_right_bottom)
    );

    always #10 clk = ~clk;

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint clamp(longint v);
        if (v > CMAX)
            return CMAX;
        if (v < CMIN)
            return CMIN;
        return v;
    endfunction

    // x of edge (x1 at y1) -> (x2 at y2) at y; quotient truncated toward zero
    function automatic longint edge_x(longint y, longint y1, longint y2,
                                      longint x1, longint x2);
        longint d, dx, t;
        logic [127:0] prod, quo;
        bit neg;
        d = y2 - y1;
        dx = x2 - x1;
        t = y - y1;
        if (d == 0 || dx == 0 || t == 0)
            return x1;
        neg = ((dx < 0) != (t < 0)) != (d < 0);
        prod = 128'(magnitude(dx)) * 128'(magnitude(t));
        quo = prod / 128'(magnitude(d));
        if (quo > (128'(1) << 62))
            quo = 128'(1) << 62;
        return clamp(neg ? x1 - longint'(quo[63:0]) : x1 + longint'(quo[63:0]));
    endfunction

    function automatic longint lo_of(longint a, longint b);
        return a < b ? a : b;
    endfunction

    function automatic longint hi_of(longint a, longint b);
        return a > b ? a : b;
    endfunction

    function automatic band_t clip_band(pair_t p);
        band_t r;
        longint yt, yb, la, lb, ra, rb;
        r = '{default: 0};
        yt = lo_of(p.ayt, p.byt);
        yb = hi_of(p.ayb, p.byb);
        if (!((p.arb >= p.blb || p.art >= p.blt) && yt > yb))
            return r;
        r.hit = 1;
        r.yt = coord_t'(yt);
        r.yb = coord_t'(yb);
        la = edge_x(yt, p.ayt, p.ayb, p.alt, p.alb);
        lb = edge_x(yt, p.byt, p.byb, p.blt, p.blb);
        ra = edge_x(yt, p.ayt, p.ayb, p.art, p.arb);
        rb = edge_x(yt, p.byt, p.byb, p.brt, p.brb);
        r.lt = coord_t'(union_mode ? lo_of(la, lb) : hi_of(la, lb));
        r.rt = coord_t'(union_mode ? hi_of(ra, rb) : lo_of(ra, rb));
        la = edge_x(yb, p.ayt, p.ayb, p.alt, p.alb);
        lb = edge_x(yb, p.byt, p.byb, p.blt, p.blb);
        ra = edge_x(yb, p.ayt, p.ayb, p.art, p.arb);
        rb = edge_x(yb, p.byt, p.byb, p.brt, p.brb);
        r.lb = coord_t'(union_mode ? lo_of(la, lb) : hi_of(la, lb));
        r.rb = coord_t'(union_mode ? hi_of(ra, rb) : lo_of(ra, rb));
        return r;
    endfunction

    task automatic send_pair(pair_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        a_left_top <= p.alt;  a_right_top <= p.art;
        a_left_bottom <= p.alb;  a_right_bottom <= p.arb;
        a_y_top <= p.ayt;  a_y_bottom <= p.ayb;
        b_left_top <= p.blt;  b_right_top <= p.brt;
        b_left_bottom <= p.blb;  b_right_bottom <= p.brb;
        b_y_top <= p.byt;  b_y_bottom <= p.byb;
        do @(posedge clk); while (in_stall);
        expected_bands.insert(expected_bands.size(), clip_band(p));
    endtask

    task automatic drain();
        in_valid <= 0;
        while (expected_bands.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_mode(logic v);
        drain();
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        union_mode = v;
    endtask

    function automatic coord_t any_coord();
        case ($urandom_range(9))
            0: return coord_t'(CMAX);
            1: return coord_t'(CMIN);
            2, 3, 4: return coord_t'($urandom);
            default: return coord_t'(int'($urandom_range(4000)) - 2000);
        endcase
    endfunction

    // Mostly overlapping bands with random edges, some raw noise
    function automatic pair_t random_pair();
        pair_t p;
        int base, span;
        p.alt = any_coord(); p.art = any_coord(); p.alb = any_coord(); p.arb = any_coord();
        p.blt = any_coord(); p.brt = any_coord(); p.blb = any_coord(); p.brb = any_coord();
        if ($urandom_range(9) < 2) begin
            p.ayt = any_coord(); p.ayb = any_coord();
            p.byt = any_coord(); p.byb = any_coord();
        end else begin
            span = $urandom_range(9) < 7 ? 3000 : 1 << 29;
            base = int'($urandom) >>> 2;
            p.ayb = base + int'($urandom_range(span));
            p.byb = base + int'($urandom_range(span));
            p.ayt = p.ayb + int'($urandom_range(span));
            p.byt = p.byb + int'($urandom_range(span));
            if ($urandom_range(3) == 0) begin
                p.arb = p.blb + int'($urandom_range(1000));
                p.art = p.blt + int'($urandom_range(1000));
            end
        end
        return p;
    endfunction

    function automatic pair_t pair_of(coord_t alt, art, alb, arb, ayt, ayb,
                                      coord_t blt, brt, blb, brb, byt, byb);
        pair_t p;
        p = '{alt, art, alb, arb, ayt, ayb, blt, brt, blb, brb, byt, byb};
        return p;
    endfunction

    task automatic test_directed();
        coord_t mx, mn;
        mx = coord_t'(CMAX);
        mn = coord_t'(CMIN);
        for (int m = 0; m < 2; m++) begin
            write_mode(m[0]);
            // plain overlap, both sloped
            send_pair(pair_of(0, 100, 10, 90, 100, 0, 50, 150, 40, 160, 80, -20));
            // y bands only touch
            send_pair(pair_of(0, 100, 0, 100, 100, 50, 0, 100, 0, 100, 50, 0));
            // disjoint in y
            send_pair(pair_of(0, 100, 0, 100, 10, 0, 0, 100, 0, 100, 40, 20));
            // x test fails at both limits
            send_pair(pair_of(0, 10, 0, 10, 100, 0, 50, 60, 50, 60, 100, 0));
            // x-disjoint pair whose inner edges would invert; the x test fails at both limits
            send_pair(pair_of(0, 100, 0, 100, 100, 0, 200, 300, 200, 300, 100, 0));
            // full-range edges
            send_pair(pair_of(mn, mx, mx, mn, mx, mn, mn, mx, mn, mx, 5, -5));
            send_pair(pair_of(mx, mx, mn, mn, mx, mn, mn, mn, mx, mx, mx, mn));
            send_pair(pair_of(mn, mn, mn, mn, mn, mn, mx, mx, mx, mx, mx, mx));
            send_pair(pair_of(mx, mx, mx, mx, mx, mn, mx, mx, mx, mx, mx, mn));
            // vertical edges
            send_pair(pair_of(-7, 7, -7, 7, 3, -3, -1, 1, -1, 1, 1000, -1000));
            send_pair(pair_of(-1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0));
        end
    endtask

    task automatic test_random(int count, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < count; i++)
            send_pair(random_pair());
    endtask

    // receiver holds off long enough that the pipeline fills and stalls the input
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 3 * LATENCY;
        for (int i = 0; i < 80; i++)
            send_pair(random_pair());
        drain();
    endtask

    always @(posedge clk) begin
        if (out_valid && !out_stall) begin
            if (expected_bands.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                band_t e;
                e = expected_bands.pop_front();
                if (overlap !== e.hit) begin
                    $error("overlap exp %0d got %0d", e.hit, overlap);
                    fail_count++;
                end
                if (out_y_top !== e.yt) begin
                    $error("out_y_top exp %0d got %0d", e.yt, out_y_top);
                    fail_count++;
                end
                if (out_y_bottom !== e.yb) begin
                    $error("out_y_bottom exp %0d got %0d", e.yb, out_y_bottom);
                    fail_count++;
                end
                if (out_left_top !== e.lt) begin
                    $error("out_left_top exp %0d got %0d", e.lt, out_left_top);
                    fail_count++;
                end
                if (out_right_top !== e.rt) begin
                    $error("out_right_top exp %0d got %0d", e.rt, out_right_top);
                    fail_count++;
                end
                if (out_left_bottom !== e.lb) begin
                    $error("out_left_bottom exp %0d got %0d", e.lb, out_left_bottom);
                    fail_count++;
                end
                if (out_right_bottom !== e.rb) begin
                    $error("out_right_bottom exp %0d got %0d", e.rb, out_right_bottom);
                    fail_count++;
                end
            end
        end
    end

    // receiver side: long hold-off count, else random idling
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        write_mode(0);
        test_random(200, 7, 86);
        test_random(200, 86, 7);
        test_random(200, 0, 0);
        test_backpressure();
        write_mode(1);
        test_random(200, 7, 86);
        test_random(200, 86, 7);
        test_random(200, 0, 0);
        drain();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tbc_pkg.sv
hdl/trapezoid_band_clip_unit.sv
tb/tb.sv
